FILE: rtl/ipv4lpr_pkg.sv
// Shared types and constants of the IPv4 longest-prefix routing unit.
// Holds the result status codes and the item record that moves down the cell chain.
// It depends on nothing else.
package ipv4lpr_pkg;

   localparam logic [2:0] ST_ADDED       = 3'd0;
   localparam logic [2:0] ST_FORWARDED   = 3'd1;
   localparam logic [2:0] ST_DROPPED_TTL = 3'd2;
   localparam logic [2:0] ST_NO_ROUTE    = 3'd3;
   localparam logic [2:0] ST_TABLE_FULL  = 3'd4;

   localparam logic [5:0] MAX_PREFIX_LEN = 6'd32;

   // One item in flight. An add item carries the new route in addr, len, gv, gw
   // and port. A lookup item carries the destination in addr, and the best
   // match found so far in len, gv, gw, port and found. While a lookup is still
   // live, its status reads ST_FORWARDED.
   typedef struct packed {
      logic        valid;
      logic        is_add;
      logic [2:0]  status;
      logic [31:0] addr;
      logic [5:0]  len;
      logic        gv;
      logic [31:0] gw;
      logic [2:0]  port;
      logic        found;
      logic [7:0]  ttl;
   } item_type;

endpackage

FILE: rtl/ipv4lpr_cell.sv
// One cell of the routing chain: it holds a single route entry.
// It stores an add item aimed at its slot and updates a passing lookup's best match.
// It depends on ipv4lpr_pkg.
module ipv4lpr_cell #(
   parameter int CELL_INDEX  = 0,
   parameter int COUNT_WIDTH = 5
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  ipv4lpr_pkg::item_type      item_in,
   input  logic [COUNT_WIDTH-1:0]     slot_in,
   output ipv4lpr_pkg::item_type      item_out,
   output logic [COUNT_WIDTH-1:0]     slot_out
);
   import ipv4lpr_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] MY_SLOT = COUNT_WIDTH'(CELL_INDEX);

   // Stored route. The entry is only read once the fill count covers it.
   logic [31:0] prefix_ff, prefix_in;
   logic [5:0]  len_ff, len_in;
   logic        gv_ff, gv_in;
   logic [31:0] gw_ff, gw_in;
   logic [2:0]  port_ff, port_in;

   item_type                item_ff, item_in_next;
   logic [COUNT_WIDTH-1:0]  slot_ff, slot_in_next;

   logic        write_entry;
   logic        entry_live;
   logic [31:0] mask;
   logic        better;

   assign mask = ~(32'hFFFF_FFFF >> len_ff);

   assign write_entry = item_in.valid && item_in.is_add &&
                        (item_in.status == ST_ADDED) && (slot_in == MY_SLOT);

   assign entry_live = MY_SLOT < slot_in;

   assign better = item_in.valid && !item_in.is_add &&
                   (item_in.status == ST_FORWARDED) && entry_live &&
                   ((item_in.addr & mask) == (prefix_ff & mask)) &&
                   (!item_in.found || (item_in.len <= len_ff));

   always_comb begin
      prefix_in    = prefix_ff;
      len_in       = len_ff;
      gv_in        = gv_ff;
      gw_in        = gw_ff;
      port_in      = port_ff;
      item_in_next = item_in;
      slot_in_next = slot_in;
      if (write_entry) begin
         prefix_in = item_in.addr;
         len_in    = item_in.len;
         gv_in     = item_in.gv;
         gw_in     = item_in.gw;
         port_in   = item_in.port;
      end
      if (better) begin
         item_in_next.found = 1'b1;
         item_in_next.len   = len_ff;
         item_in_next.gv    = gv_ff;
         item_in_next.gw    = gw_ff;
         item_in_next.port  = port_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prefix_ff <= prefix_in;
         len_ff    <= len_in;
         gv_ff     <= gv_in;
         gw_ff     <= gw_in;
         port_ff   <= port_in;
         slot_ff   <= slot_in_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff <= '0;
      end else if (advance) begin
         item_ff <= item_in_next;
      end
   end

   assign item_out = item_ff;
   assign slot_out = slot_ff;

endmodule

FILE: rtl/ipv4_longest_prefix_router_unit.sv
// IPv4 longest-prefix routing unit: top level with entry logic, cell chain and output register.
// It depends on ipv4lpr_pkg and ipv4lpr_cell.
//
// An item is loaded into the first of the MAX_ROUTES cells of the route chain at the edge
// that accepts it. It then moves one cell per cycle while the chain advances and reaches
// the output register, where its result is offered. While a finished result waits on
// rsp_stall, the whole chain holds with every item inside it. Items enter back to back, one
// per cycle while nothing holds the chain, and move down the chain together. The chain
// advances whenever the output register is empty or its item is taken, so the sustained
// rate is one item per cycle. An add item is given its slot (the current
// route count) on entry and is written into the cell of that slot as it passes;
// when all MAX_ROUTES slots are in use it reports table full instead. A route item
// with a TTL of 0 or 1 is marked dropped on entry. Any other route item collects the
// longest matching prefix as it passes each filled cell; equal lengths go to the
// later entry, and length 0 matches any address. Because items never overtake each
// other, a route item sees exactly the routes added before it. Status codes: 0 added,
// 1 forwarded, 2 dropped ttl, 3 no route, 4 table full; on anything but forwarded the
// port, hop address and TTL of the result are 0. There is no clearing pass after reset.
module ipv4_longest_prefix_router_unit #(
   parameter int MAX_ROUTES = 16,
   parameter int NUM_PORTS  = 8
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [31:0] req_net_prefix,
   input  logic [5:0]  req_prefix_len,
   input  logic        req_has_next_hop,
   input  logic [31:0] req_gateway_addr,
   input  logic [2:0]  req_port_index,
   input  logic [31:0] req_dest_addr,
   input  logic [7:0]  req_ttl_in,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [2:0]  rsp_out_port,
   output logic [31:0] rsp_out_hop_addr,
   output logic [7:0]  rsp_ttl_out
);
   import ipv4lpr_pkg::*;

   localparam int COUNT_WIDTH = $clog2(MAX_ROUTES + 1);
   localparam logic [COUNT_WIDTH-1:0] TABLE_SIZE = COUNT_WIDTH'(MAX_ROUTES);
   localparam logic [8:0] PORT_LIMIT = 9'(NUM_PORTS);
   localparam int PORT_VALUES = 8;

   logic advance;
   logic accept;
   logic table_full;

   logic [COUNT_WIDTH-1:0] entry_count_ff, entry_count_in;

   item_type               head_item;
   logic [5:0]             sat_len;
   logic [8:0]             port_mod;

   item_type               chain_item [0:MAX_ROUTES];
   logic [COUNT_WIDTH-1:0] chain_slot [0:MAX_ROUTES];

   item_type               tail;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  status_ff, status_in;
   logic [2:0]  out_port_ff, out_port_in;
   logic [31:0] hop_ff, hop_in;
   logic [7:0]  ttl_ff, ttl_in;

   // The whole chain moves as one; it holds only while a finished result waits.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign accept    = req_valid && advance;

   assign table_full = (entry_count_ff == TABLE_SIZE);

   always_comb begin
      entry_count_in = entry_count_ff;
      if (accept && !req_opcode && !table_full) begin
         entry_count_in = entry_count_ff + COUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else begin
         entry_count_ff <= entry_count_in;
      end
   end

   // Lengths above 32 are treated as 32.
   assign sat_len = (req_prefix_len > MAX_PREFIX_LEN) ? MAX_PREFIX_LEN : req_prefix_len;

   // Interface number reduced modulo NUM_PORTS by repeated subtraction; the
   // three-bit value needs at most eight steps.
   always_comb begin
      port_mod = {6'd0, req_port_index};
      for (int k = 0; k < PORT_VALUES; k++) begin
         if (port_mod >= PORT_LIMIT) begin
            port_mod = port_mod - PORT_LIMIT;
         end
      end
   end

   always_comb begin
      head_item        = '0;
      head_item.valid  = req_valid;
      head_item.is_add = !req_opcode;
      head_item.ttl    = req_ttl_in;
      if (!req_opcode) begin
         head_item.status = table_full ? ST_TABLE_FULL : ST_ADDED;
         head_item.addr   = req_net_prefix;
         head_item.len    = sat_len;
         head_item.gv     = req_has_next_hop;
         head_item.gw     = req_has_next_hop ? req_gateway_addr : 32'd0;
         head_item.port   = port_mod[2:0];
      end else begin
         head_item.status = (req_ttl_in <= 8'd1) ? ST_DROPPED_TTL : ST_FORWARDED;
         head_item.addr   = req_dest_addr;
      end
   end

   assign chain_item[0] = head_item;
   assign chain_slot[0] = entry_count_ff;

   for (genvar i = 0; i < MAX_ROUTES; i++) begin : g_cell
      ipv4lpr_cell #(
         .CELL_INDEX  (i),
         .COUNT_WIDTH (COUNT_WIDTH)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .item_in  (chain_item[i]),
         .slot_in  (chain_slot[i]),
         .item_out (chain_item[i+1]),
         .slot_out (chain_slot[i+1])
      );
   end

   assign tail = chain_item[MAX_ROUTES];

   // Turn the item leaving the chain into its result.
   always_comb begin
      rsp_valid_in = tail.valid;
      status_in    = tail.status;
      out_port_in  = 3'd0;
      hop_in       = 32'd0;
      ttl_in       = 8'd0;
      if (!tail.is_add && (tail.status == ST_FORWARDED)) begin
         if (tail.found) begin
            out_port_in = tail.port;
            hop_in      = tail.gv ? tail.gw : tail.addr;
            ttl_in      = tail.ttl - 8'd1;
         end else begin
            status_in = ST_NO_ROUTE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         status_ff   <= status_in;
         out_port_ff <= out_port_in;
         hop_ff      <= hop_in;
         ttl_ff      <= ttl_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_out_port     = out_port_ff;
   assign rsp_out_hop_addr = hop_ff;
   assign rsp_ttl_out      = ttl_ff;

endmodule

FILE: sim/ipv4_longest_prefix_router_unit_test.sv
// Self-checking testbench of the IPv4 longest-prefix routing unit.
// Drives add and lookup items, predicts every result and compares it field by field.
// It depends on ipv4lpr_pkg and ipv4_longest_prefix_router_unit.
`timescale 1ns / 100ps

module ipv4_longest_prefix_router_unit_test;
   import ipv4lpr_pkg::*;

   localparam int MAX_ROUTES = 16;
   localparam int NUM_PORTS  = 8;

   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_ROUTE = 1'b1;

   localparam int RANDOM_ITEMS = 600;

   // One input item, in the order of the request ports.
   typedef struct packed {
      logic        opcode;
      logic [31:0] net_prefix;
      logic [5:0]  prefix_len;
      logic        has_next_hop;
      logic [31:0] gateway_addr;
      logic [2:0]  port_index;
      logic [31:0] dest_addr;
      logic [7:0]  ttl_in;
   } route_req_type;

   // One result item, in the order of the result ports.
   typedef struct packed {
      logic [2:0]  status;
      logic [2:0]  out_port;
      logic [31:0] out_hop_addr;
      logic [7:0]  ttl_out;
   } route_rsp_type;

   // A directed row. When pinned is set, the result is typed in the row; otherwise the
   // forwarding predictor supplies it.
   typedef struct packed {
      route_req_type req;
      logic          pinned;
      route_rsp_type want;
   } probe_row_type;

   localparam route_rsp_type NO_PIN = '0;
   localparam int PROBE_COUNT = 24;

   // The directed part never adds a length-0 route, so that a lookup can still miss
   // once the table holds entries. The default route is added late in the random part.
   localparam probe_row_type PROBE_ROWS [PROBE_COUNT] = '{
      // Right after reset: low TTL drops, and an empty table finds no route.
      '{'{OP_ROUTE, 32'h0000_0000, 6'd0, 1'b0, 32'h0000_0000, 3'd0, 32'h0000_0000, 8'd0},
        1'b1, '{ST_DROPPED_TTL, 3'd0, 32'h0, 8'd0}},
      '{'{OP_ROUTE, 32'h0000_0000, 6'd0, 1'b0, 32'h0000_0000, 3'd0, 32'hFFFF_FFFF, 8'd1},
        1'b1, '{ST_DROPPED_TTL, 3'd0, 32'h0, 8'd0}},
      '{'{OP_ROUTE, 32'h0000_0000, 6'd0, 1'b0, 32'h0000_0000, 3'd0, 32'h0000_0000, 8'd255},
        1'b1, '{ST_NO_ROUTE, 3'd0, 32'h0, 8'd0}},
      // Route fields of a lookup are all ones and must be ignored.
      '{'{OP_ROUTE, 32'hFFFF_FFFF, 6'd63, 1'b1, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF, 8'd2},
        1'b1, '{ST_NO_ROUTE, 3'd0, 32'h0, 8'd0}},
      // Host route with a gateway, then a lookup at the smallest TTL that forwards.
      '{'{OP_ADD, 32'hFFFF_FFFF, 6'd32, 1'b1, 32'h1234_5678, 3'd7, 32'hFFFF_FFFF, 8'd255},
        1'b1, '{ST_ADDED, 3'd0, 32'h0, 8'd0}},
      '{'{OP_ROUTE, 32'h0000_0000, 6'd0, 1'b0, 32'h0000_0000, 3'd0, 32'hFFFF_FFFF, 8'd2},
        1'b1, '{ST_FORWARDED, 3'd7, 32'h1234_5678, 8'd1}},
      '{'{OP_ROUTE, 32'h0000_0000, 6'd0, 1'b0, 32'h0000_0000, 3'd0, 32'hFFFF_FFFE, 8'd255},
        1'b1, '{ST_NO_ROUTE, 3'd0, 32'h0, 8'd0}},
      // A length above 32 saturates; the gateway of a direct route is dropped.
      '{'{OP_ADD, 32'h0A00_0001, 6'd63, 1'b0, 32'hDEAD_BEEF, 3'd5, 32'h0000_0000, 8'd0},
        1'b1, '{ST_ADDED, 3'd0, 32'h0, 8'd0}},
      '{'{OP_ROUTE, 32'h0000_0000, 6'd0, 1'b0, 32'h0000_0000, 3'd0, 32'h0A00_0001, 8'd64},
        1'b0, NO_PIN},
      '{'{OP_ROUTE, 32'h0000_0000, 6'd0, 1'b0, 32'h0000_0000, 3'd0, 32'h0A00_0000, 8'd64},
        1'b0, NO_PIN},
      // Two /16 routes with the same masked prefix: the later one must win.
      '{'{OP_ADD, 32'hC0A8_0000, 6'd16, 1'b1, 32'hC0A8_0001, 3'd2, 32'h0000_0000, 8'd0},
        1'b1, '{ST_ADDED, 3'd0, 32'h0, 8'd0}},
      '{'{OP_ROUTE, 32'h0000_0000, 6'd0, 1'b0, 32'h0000_0000, 3'd0, 32'hC0A8_FFFF, 8'd10},
        1'b0, NO_PIN},
      '{'{OP_ADD, 32'hC0A8_FFFF, 6'd16, 1'b0, 32'hFFFF_FFFF, 3'd3, 32'hFFFF_FFFF, 8'd255},
        1'b1, '{ST_ADDED, 3'd0, 32'h0, 8'd0}},
      '{'{OP_ROUTE, 32'h0000_0000, 6'd0, 1'b0, 32'h0000_0000, 3'd0, 32'hC0A8_1234, 8'd10},
        1'b0, NO_PIN},
      // A longer prefix beats the /16 inside its range only.
      '{'{OP_ADD, 32'hC0A8_1200, 6'd24, 1'b1, 32'h0A0A_0A0A, 3'd0, 32'h0000_0000, 8'd0},
        1'b1, '{ST_ADDED, 3'd0, 32'h0, 8'd0}},
      '{'{OP_ROUTE, 32'h0000_0000, 6'd0, 1'b0, 32'h0000_0000, 3'd0, 32'hC0A8_12FF, 8'd200},
        1'b0, NO_PIN},
      '{'{OP_ROUTE, 32'h0000_0000, 6'd0, 1'b0, 32'h0000_0000, 3'd0, 32'hC0A8_1300, 8'd200},
        1'b0, NO_PIN},
      '{'{OP_ADD, 32'h8000_0000, 6'd1, 1'b1, 32'h0000_0000, 3'd6, 32'h0000_0000, 8'd0},
        1'b1, '{ST_ADDED, 3'd0, 32'h0, 8'd0}},
      '{'{OP_ROUTE, 32'h0000_0000, 6'd0, 1'b0, 32'h0000_0000, 3'd0, 32'hFFFF_FFFF, 8'd255},
        1'b0, NO_PIN},
      '{'{OP_ROUTE, 32'h0000_0000, 6'd0, 1'b0, 32'h0000_0000, 3'd0, 32'h7FFF_FFFF, 8'd3},
        1'b0, NO_PIN},
      // All fields at their maximum; the second host route replaces the first.
      '{'{OP_ADD, 32'hFFFF_FFFF, 6'd32, 1'b1, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF, 8'd255},
        1'b1, '{ST_ADDED, 3'd0, 32'h0, 8'd0}},
      '{'{OP_ROUTE, 32'h0000_0000, 6'd0, 1'b0, 32'h0000_0000, 3'd0, 32'hFFFF_FFFF, 8'd255},
        1'b0, NO_PIN},
      // A matching route does not save a datagram whose TTL has run out.
      '{'{OP_ROUTE, 32'h0000_0000, 6'd0, 1'b0, 32'h0000_0000, 3'd0, 32'h0A00_0001, 8'd0},
        1'b1, '{ST_DROPPED_TTL, 3'd0, 32'h0, 8'd0}},
      '{'{OP_ROUTE, 32'h0000_0000, 6'd0, 1'b0, 32'h0000_0000, 3'd0, 32'hC0A8_1201, 8'd2},
        1'b0, NO_PIN}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic        req_opcode       = 1'b0;
   logic [31:0] req_net_prefix   = '0;
   logic [5:0]  req_prefix_len   = '0;
   logic        req_has_next_hop = 1'b0;
   logic [31:0] req_gateway_addr = '0;
   logic [2:0]  req_port_index   = '0;
   logic [31:0] req_dest_addr    = '0;
   logic [7:0]  req_ttl_in       = '0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [2:0]  rsp_out_port;
   logic [31:0] rsp_out_hop_addr;
   logic [7:0]  rsp_ttl_out;

   // While calm is set, neither side idles or stalls.
   logic        calm = 1'b0;

   // The predictor's own copy of the routing table.
   logic [31:0] tbl_prefix [MAX_ROUTES];
   logic [5:0]  tbl_len    [MAX_ROUTES];
   logic        tbl_has_gw [MAX_ROUTES];
   logic [31:0] tbl_gw     [MAX_ROUTES];
   logic [2:0]  tbl_port   [MAX_ROUTES];
   int          route_count = 0;

   route_rsp_type expected_verdicts [$];
   route_rsp_type oldest_verdict;
   int            fault_count = 0;

   ipv4_longest_prefix_router_unit #(
      .MAX_ROUTES(MAX_ROUTES),
      .NUM_PORTS (NUM_PORTS)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_net_prefix  (req_net_prefix),
      .req_prefix_len  (req_prefix_len),
      .req_has_next_hop(req_has_next_hop),
      .req_gateway_addr(req_gateway_addr),
      .req_port_index  (req_port_index),
      .req_dest_addr   (req_dest_addr),
      .req_ttl_in      (req_ttl_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_out_port    (rsp_out_port),
      .rsp_out_hop_addr(rsp_out_hop_addr),
      .rsp_ttl_out     (rsp_ttl_out)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Mask of the high-order len bits; a shift by 32 leaves nothing, so length 0 gives 0.
   function automatic logic [31:0] prefix_mask(input logic [5:0] len);
      return 32'hFFFF_FFFF << (32 - len);
   endfunction

   // Applies one accepted item to the table copy and returns the result it causes.
   function automatic route_rsp_type forward_verdict(input route_req_type r);
      route_rsp_type v;
      logic          found;
      logic [5:0]    best_len;
      int            best;
      logic [31:0]   m;
      v        = '0;
      found    = 1'b0;
      best_len = '0;
      best     = 0;
      if (r.opcode == OP_ADD) begin
         if (route_count >= MAX_ROUTES) begin
            v.status = ST_TABLE_FULL;
         end else begin
            tbl_prefix[route_count] = r.net_prefix;
            tbl_len[route_count]    = (r.prefix_len > MAX_PREFIX_LEN) ? MAX_PREFIX_LEN
                                                                      : r.prefix_len;
            tbl_has_gw[route_count] = r.has_next_hop;
            tbl_gw[route_count]     = r.has_next_hop ? r.gateway_addr : 32'h0;
            tbl_port[route_count]   = 3'(r.port_index % NUM_PORTS);
            route_count++;
            v.status = ST_ADDED;
         end
      end else if (r.ttl_in <= 8'd1) begin
         v.status = ST_DROPPED_TTL;
      end else begin
         // Walking in insertion order with <= lets a later entry of equal length win.
         for (int i = 0; i < route_count; i++) begin
            m = prefix_mask(tbl_len[i]);
            if (((r.dest_addr ^ tbl_prefix[i]) & m) == 32'h0 &&
                (!found || best_len <= tbl_len[i])) begin
               found    = 1'b1;
               best_len = tbl_len[i];
               best     = i;
            end
         end
         if (!found) begin
            v.status = ST_NO_ROUTE;
         end else begin
            v.status       = ST_FORWARDED;
            v.out_port     = tbl_port[best];
            v.out_hop_addr = tbl_has_gw[best] ? tbl_gw[best] : r.dest_addr;
            v.ttl_out      = r.ttl_in - 8'd1;
         end
      end
      return v;
   endfunction

   // Builds one random item. Most lookups aim inside a stored prefix, and many adds
   // nest inside or tie with an existing route, so that the match logic is exercised.
   function automatic route_req_type random_request(input int n);
      route_req_type r;
      int            k;
      logic [31:0]   m;
      r.net_prefix   = $urandom;
      r.prefix_len   = ($urandom_range(0, 99) < 10) ? 6'($urandom_range(33, 63))
                                                    : 6'($urandom_range(1, 32));
      r.has_next_hop = 1'($urandom_range(0, 1));
      r.gateway_addr = $urandom;
      r.port_index   = 3'($urandom_range(0, 7));
      r.dest_addr    = $urandom;
      r.ttl_in       = 8'($urandom_range(0, 255));
      r.opcode       = ($urandom_range(0, 99) < 15) ? OP_ADD : OP_ROUTE;
      // The last free slot is kept for a default route, added only in the second half
      // so that misses stay possible for a good while.
      if (r.opcode == OP_ADD && route_count == MAX_ROUTES - 1 && n < RANDOM_ITEMS / 2)
         r.opcode = OP_ROUTE;
      if (r.opcode == OP_ADD) begin
         if (route_count == MAX_ROUTES - 1) begin
            r.prefix_len = 6'd0;
         end else if (route_count > 0 && $urandom_range(0, 99) < 40) begin
            k = $urandom_range(0, route_count - 1);
            m = prefix_mask(tbl_len[k]);
            r.net_prefix = (tbl_prefix[k] & m) | ($urandom & ~m);
            r.prefix_len = 6'($urandom_range(32, tbl_len[k]));
         end
      end else begin
         if (route_count > 0 && $urandom_range(0, 99) < 70) begin
            k = $urandom_range(0, route_count - 1);
            m = prefix_mask(tbl_len[k]);
            r.dest_addr = (tbl_prefix[k] & m) | ($urandom & ~m);
         end
         r.ttl_in = ($urandom_range(0, 99) < 10) ? 8'($urandom_range(0, 1))
                                                 : 8'($urandom_range(2, 255));
      end
      return r;
   endfunction

   // Offers one item, holds it while stalled, and records its expected result on the
   // edge at which it is taken.
   task automatic offer_item(input route_req_type r, input logic pinned,
                             input route_rsp_type want);
      route_rsp_type verdict;
      while (!calm && $urandom_range(0, 99) < 12) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_opcode       <= r.opcode;
      req_net_prefix   <= r.net_prefix;
      req_prefix_len   <= r.prefix_len;
      req_has_next_hop <= r.has_next_hop;
      req_gateway_addr <= r.gateway_addr;
      req_port_index   <= r.port_index;
      req_dest_addr    <= r.dest_addr;
      req_ttl_in       <= r.ttl_in;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      verdict = forward_verdict(r);
      expected_verdicts = {expected_verdicts, (pinned ? want : verdict)};
   endtask

   // Lowers valid and waits until every result so far has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
   endtask

   // Receiver: stalls at random outside the calm stretch.
   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(0, 99) < 12);
   end

   // Result checker: every taken result is matched against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_verdicts.size() == 0) begin
            $error("unexpected result item: status %0d", rsp_status);
            fault_count++;
         end else begin
            oldest_verdict = expected_verdicts.pop_front();
            if (rsp_status !== oldest_verdict.status) begin
               $error("status: expected %0d, got %0d", oldest_verdict.status, rsp_status);
               fault_count++;
            end
            if (rsp_out_port !== oldest_verdict.out_port) begin
               $error("out_port: expected %0d, got %0d",
                      oldest_verdict.out_port, rsp_out_port);
               fault_count++;
            end
            if (rsp_out_hop_addr !== oldest_verdict.out_hop_addr) begin
               $error("out_hop_addr: expected %h, got %h",
                      oldest_verdict.out_hop_addr, rsp_out_hop_addr);
               fault_count++;
            end
            if (rsp_ttl_out !== oldest_verdict.ttl_out) begin
               $error("ttl_out: expected %0d, got %0d",
                      oldest_verdict.ttl_out, rsp_ttl_out);
               fault_count++;
            end
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < PROBE_COUNT; i++)
         offer_item(PROBE_ROWS[i].req, PROBE_ROWS[i].pinned, PROBE_ROWS[i].want);
      drain_results();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // Halfway through, the sender waits for the pipeline to run dry.
         if (n == RANDOM_ITEMS / 2)
            drain_results();
         calm <= (n >= 400 && n < 520);
         offer_item(random_request(n), 1'b0, NO_PIN);
      end
      drain_results();

      // An idle wait longer than the chain, to catch stray results.
      repeat (MAX_ROUTES + 8) @(posedge clock);
      if (fault_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // Watchdog: a run that has not finished in time ends as failed.
   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
